### design/assert_macros.svh
// assertion macros for the checker file clcd_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// types, codes and the cyrillic map for the character lcd command writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clcd_pkg;

    localparam int STROBE_PHASE_US_DEF = 40;
    localparam int QUEUE_DEPTH_DEF     = 4;

    typedef enum logic [2:0] {
        OP_CHAR  = 3'd0,
        OP_CLEAR = 3'd1,
        OP_FSET  = 3'd2,
        OP_ONOFF = 3'd3,
        OP_ENTRY = 3'd4,
        OP_POS   = 3'd5,
        OP_INIT  = 3'd6,
        OP_NONE  = 3'd7
    } t_opcode;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] char_code;
        logic        two_line;
        logic        large_font;
        logic        display_on;
        logic        cursor_on;
        logic        blink_on;
        logic        move_forward;
        logic        shift_screen;
        logic        row;
        logic [5:0]  column;
    } t_cmd;

    typedef struct packed {
        logic        reg_select;
        logic        read_write;
        logic [7:0]  data_pins;
        logic        nibble_write;
        logic [14:0] wait_before_us;
        logic [10:0] wait_after_us;
        logic        last;
    } t_strobe;

    // classified work item: a plain byte or the init sequence
    typedef struct packed {
        logic       is_init;
        logic       reg_select;
        logic [7:0] data_byte;
        logic       long_wait;
        logic [7:0] fset_byte;
        logic       bus_8bit;
    } t_job;

    typedef struct packed {
        logic push;
        logic full;
    } t_qctl;

    localparam logic [7:0] CYR_HI_D0 = 8'hd0;
    localparam logic [7:0] CYR_HI_D1 = 8'hd1;

    localparam logic [14:0] WAIT_20000 = 15'd20000;
    localparam logic [14:0] WAIT_5000  = 15'd5000;
    localparam logic [14:0] WAIT_1000  = 15'd1000;
    localparam logic [10:0] WAIT_CLEAR = 11'd2000;
    localparam logic [10:0] WAIT_A1000 = 11'd1000;

    function automatic logic [7:0] cyr_d0(input logic [5:0] idx);
        logic [7:0] m;
        case (idx)
            6'd1:  m = 8'ha2;  6'd16: m = 8'h41;  6'd17: m = 8'ha0;
            6'd18: m = 8'h42;  6'd19: m = 8'ha1;  6'd20: m = 8'he0;
            6'd21: m = 8'h45;  6'd22: m = 8'ha3;  6'd23: m = 8'ha4;
            6'd24: m = 8'ha5;  6'd25: m = 8'ha6;  6'd26: m = 8'h4b;
            6'd27: m = 8'ha7;  6'd28: m = 8'h4d;  6'd29: m = 8'h48;
            6'd30: m = 8'h4f;  6'd31: m = 8'ha8;  6'd32: m = 8'h50;
            6'd33: m = 8'h43;  6'd34: m = 8'h54;  6'd35: m = 8'ha9;
            6'd36: m = 8'haa;  6'd37: m = 8'h58;  6'd38: m = 8'he1;
            6'd39: m = 8'hab;  6'd40: m = 8'hac;  6'd41: m = 8'he2;
            6'd42: m = 8'had;  6'd43: m = 8'hae;  6'd44: m = 8'had;
            6'd45: m = 8'haf;  6'd46: m = 8'hb0;  6'd47: m = 8'hb1;
            6'd48: m = 8'h61;  6'd49: m = 8'hb2;  6'd50: m = 8'hb3;
            6'd51: m = 8'hb4;  6'd52: m = 8'he3;  6'd53: m = 8'h65;
            6'd54: m = 8'hb6;  6'd55: m = 8'hb7;  6'd56: m = 8'hb8;
            6'd57: m = 8'hb9;  6'd58: m = 8'hba;  6'd59: m = 8'hbb;
            6'd60: m = 8'hbc;  6'd61: m = 8'hbd;  6'd62: m = 8'h6f;
            6'd63: m = 8'hbe;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] cyr_d1(input logic [4:0] idx);
        logic [7:0] m;
        case (idx)
            5'd0:  m = 8'h70;  5'd1:  m = 8'h63;  5'd2:  m = 8'hbf;
            5'd3:  m = 8'h79;  5'd4:  m = 8'he4;  5'd5:  m = 8'h78;
            5'd6:  m = 8'he5;  5'd7:  m = 8'hc0;  5'd8:  m = 8'hc1;
            5'd9:  m = 8'he6;  5'd10: m = 8'hc2;  5'd11: m = 8'hc3;
            5'd12: m = 8'hc4;  5'd13: m = 8'hc5;  5'd14: m = 8'hc6;
            5'd15: m = 8'hc7;  5'd17: m = 8'hb5;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

### design/clcd_front.sv
// ----------------------------------------------------------------------------
// clcd_front
// classifies one command and maps the character code into a job
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clcd_front
    import clcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_cmd  i_cmd,
    input  logic  i_bus_8bit,
    output logic  o_push,
    output t_job  o_job
);

    logic [7:0] w_hi;
    logic [7:0] w_lo;
    logic [7:0] w_map;
    logic [7:0] w_fset;
    t_job       n_job;
    logic       n_push;
    logic       r_push;
    t_job       r_job;

    assign w_hi = i_cmd.char_code[15:8];
    assign w_lo = i_cmd.char_code[7:0];
    assign w_fset = {2'b00, 1'b1, i_bus_8bit, i_cmd.two_line, i_cmd.large_font, 2'b00};

    always_comb begin
        w_map = 8'h00;
        if (w_hi == CYR_HI_D0 && w_lo[7:6] == 2'b10) begin
            w_map = cyr_d0(w_lo[5:0]);
        end else if (w_hi == CYR_HI_D1 && w_lo[7:5] == 3'b100) begin
            w_map = cyr_d1(w_lo[4:0]);
        end
        if (w_map == 8'h00) begin
            w_map = w_lo;
        end
    end

    always_comb begin
        n_job = '0;
        n_job.fset_byte = w_fset;
        n_job.bus_8bit = i_bus_8bit;
        n_push = i_take;
        case (t_opcode'(i_cmd.opcode))
            OP_CHAR: begin
                n_job.reg_select = 1'b1;
                n_job.data_byte = w_map;
            end
            OP_CLEAR: begin
                n_job.data_byte = 8'h01;
                n_job.long_wait = 1'b1;
            end
            OP_FSET:  n_job.data_byte = w_fset;
            OP_ONOFF: n_job.data_byte = {5'b00001, i_cmd.display_on,
                                         i_cmd.cursor_on, i_cmd.blink_on};
            OP_ENTRY: n_job.data_byte = {6'b000001, i_cmd.move_forward,
                                         i_cmd.shift_screen};
            OP_POS:   n_job.data_byte = {1'b1, i_cmd.row, i_cmd.column};
            OP_INIT:  n_job.is_init = 1'b1;
            default:  n_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push <= 1'b0;
        end else begin
            r_push <= n_push;
        end
        r_job <= n_job;
    end

    assign o_push = r_push;
    assign o_job  = r_job;

endmodule

### design/clcd_queue.sv
// ----------------------------------------------------------------------------
// clcd_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clcd_queue
    import clcd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_empty,
    output t_qctl o_ctl,
    output t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [AW:0]   n_cnt;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_ctl.push = i_push;
    assign o_ctl.full = (r_cnt >= (AW+1)'(DEPTH - 1));
    assign o_job = r_mem[r_rd];

endmodule

### design/clcd_back.sv
// ----------------------------------------------------------------------------
// clcd_back
// sequences the strobe beats of one job, one beat per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clcd_back
    import clcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_busy,
    output logic    o_strobe,
    output t_strobe o_beat
);

    logic [3:0] r_step;
    logic       r_act;
    logic [3:0] n_step;
    logic       n_act;
    logic [3:0] w_cnt;
    logic       w_act;
    logic [3:0] w_step;
    logic [7:0] w_byte;
    logic [14:0] w_wb;
    logic [10:0] w_wa;
    logic        w_nib;
    logic        w_hi_half;
    logic [2:0]  w_bi;
    t_strobe     n_beat;
    logic        r_strobe;
    t_strobe     r_beat;

    assign w_act  = r_act || !i_empty;
    assign w_step = r_act ? r_step : 4'd0;

    always_comb begin
        w_cnt = 4'd1;
        if (i_job.is_init) begin
            w_cnt = i_job.bus_8bit ? 4'd7 : 4'd13;
        end else if (!i_job.bus_8bit) begin
            w_cnt = 4'd2;
        end
    end

    always_comb begin
        w_byte = i_job.data_byte;
        w_wb = '0;
        w_wa = '0;
        w_nib = !i_job.bus_8bit;
        w_hi_half = 1'b1;
        w_bi = 3'd0;
        if (!i_job.bus_8bit) begin
            w_hi_half = !w_step[0];
        end
        if (!i_job.is_init) begin
            if (i_job.long_wait && (i_job.bus_8bit || w_step[0])) begin
                w_wa = WAIT_CLEAR;
            end
        end else begin
            if (i_job.bus_8bit) begin
                if (w_step < 4'd3) begin
                    w_bi = 3'd0;
                    w_wb = (w_step == 4'd0) ? WAIT_20000 :
                           (w_step == 4'd1) ? WAIT_5000 : WAIT_1000;
                end else begin
                    w_bi = 3'(w_step - 4'd2);
                end
            end else begin
                if (w_step < 4'd3) begin
                    w_bi = 3'd0;
                    w_hi_half = 1'b1;
                    w_wb = (w_step == 4'd0) ? WAIT_20000 :
                           (w_step == 4'd1) ? WAIT_5000 : WAIT_1000;
                end else if (w_step == 4'd3) begin
                    w_bi = 3'd5;
                    w_hi_half = 1'b1;
                    w_wb = WAIT_1000;
                end else if (w_step == 4'd4) begin
                    w_bi = 3'd6;
                    w_hi_half = 1'b1;
                    w_wa = WAIT_A1000;
                end else begin
                    w_bi = 3'(((w_step - 4'd5) >> 1) + 4'd1);
                    w_hi_half = w_step[0];
                end
            end
            case (w_bi)
                3'd0: w_byte = 8'h30;
                3'd1: w_byte = i_job.fset_byte;
                3'd2: w_byte = 8'h08;
                3'd3: w_byte = 8'h01;
                3'd4: w_byte = 8'h06;
                3'd5: w_byte = 8'h10;
                3'd6: w_byte = 8'h20;
                default: w_byte = 8'h00;
            endcase
            if (w_bi == 3'd3 && (i_job.bus_8bit || !w_hi_half)) begin
                w_wa = WAIT_CLEAR;
            end
        end
        n_beat.reg_select = i_job.reg_select;
        n_beat.read_write = 1'b0;
        n_beat.nibble_write = w_nib;
        n_beat.wait_before_us = w_hi_half ? w_wb : '0;
        n_beat.wait_after_us = w_wa;
        n_beat.last = (w_step == w_cnt - 4'd1);
        if (i_job.bus_8bit) begin
            n_beat.data_pins = w_byte;
        end else begin
            n_beat.data_pins = w_hi_half ? {w_byte[7:4], 4'h0} : {w_byte[3:0], 4'h0};
        end
    end

    always_comb begin
        n_act = r_act;
        n_step = r_step;
        o_pop = 1'b0;
        if (w_act) begin
            if (n_beat.last) begin
                o_pop = 1'b1;
                n_act = 1'b0;
                n_step = '0;
            end else begin
                n_act = 1'b1;
                n_step = w_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_step <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_act <= n_act;
            r_step <= n_step;
            r_strobe <= w_act;
        end
        r_beat <= n_beat;
    end

    assign o_busy = r_act;
    assign o_strobe = r_strobe;
    assign o_beat = r_beat;

endmodule

### design/char_lcd_command_writer.sv
// ----------------------------------------------------------------------------
// char_lcd_command_writer
// command-driven strobe writer for an hd44780-style character lcd bus
// ----------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low. It is mapped into
// a registered job and queued; the sequencer then emits one strobe beat per
// clock on o_result with o_result_valid high, the final beat marked by last. A
// command gives 1 or 2 beats, init 7 (8-bit bus) or 13 (4-bit bus). The
// sequencer sets the rate: one beat per cycle; commands queue meanwhile. Beats
// cannot be held off. o_busy rises when the job queue is nearly full. The user
// must write the bus width register only while idle; it is not enforced.
`timescale 1ns / 1ps

module char_lcd_command_writer
    import clcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    input  logic    i_cfg_we,
    input  logic    i_cfg_data,
    output logic    o_result_valid,
    output t_strobe o_result
);

    logic  r_bus_8bit;
    logic  w_push;
    t_job  w_fjob;
    t_job  w_qjob;
    logic  w_empty;
    logic  w_pop;
    logic  w_bbusy;
    t_qctl w_qctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_8bit <= 1'b0;
        end else if (i_cfg_we) begin
            r_bus_8bit <= i_cfg_data;
        end
    end

    assign o_busy = w_qctl.full;

    clcd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(i_start && !o_busy),
        .i_cmd(i_cmd), .i_bus_8bit(r_bus_8bit), .o_push(w_push), .o_job(w_fjob)
    );

    clcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_job(w_fjob),
        .i_pop(w_pop), .o_empty(w_empty), .o_ctl(w_qctl), .o_job(w_qjob)
    );

    clcd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_job(w_qjob),
        .o_pop(w_pop), .o_busy(w_bbusy), .o_strobe(o_result_valid), .o_beat(o_result)
    );

endmodule

### design/clcd_checker.sv
// ----------------------------------------------------------------------------
// clcd_checker
// port-level checks for the character lcd command writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clcd_checker
    import clcd_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_start,
    input logic    o_busy,
    input logic    o_result_valid,
    input t_strobe o_result
);

    `ASSERT_IMPL(a_rw_zero, i_clk, i_rst_n, o_result_valid, o_result.read_write == 1'b0)
    `ASSERT_IMPL(a_nib_low, i_clk, i_rst_n, o_result_valid && o_result.nibble_write, o_result.data_pins[3:0] == 4'h0)
    `ASSERT_NEXT(a_start_out, i_clk, i_rst_n, i_start && !o_busy && !o_result_valid, 1'b1)

endmodule

bind char_lcd_command_writer clcd_checker u_clcd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_result_valid(o_result_valid), .o_result(o_result)
);

### tb/char_lcd_command_writer_test.sv
// ----------------------------------------------------------------------------
// char_lcd_command_writer_test
// drives lcd commands over the start/busy port under both bus widths and checks
// every strobe beat against a predicted strobe sequence, field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_lcd_command_writer_test;
    import clcd_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    start;
    t_cmd    cmd;
    logic    busy;
    logic    cfg_we;
    logic    cfg_data;
    logic    res_valid;
    t_strobe res;

    t_cmd    cmd_q[$];
    t_strobe strobe_q[$];
    logic    bus8;
    int      errors;
    int      gap_left;
    bit      gaps_on;
    bit      hold_send;

    char_lcd_command_writer dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_cmd          (cmd),
        .o_busy         (busy),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] lcd_code(logic [15:0] code);
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] m;
        logic [7:0] d0_map[64];
        logic [7:0] d1_map[32];
        hi = code[15:8];
        lo = code[7:0];
        m = 8'h00;
        d0_map = '{8'h00, 8'ha2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h41, 8'ha0, 8'h42, 8'ha1, 8'he0, 8'h45, 8'ha3, 8'ha4,
                   8'ha5, 8'ha6, 8'h4b, 8'ha7, 8'h4d, 8'h48, 8'h4f, 8'ha8,
                   8'h50, 8'h43, 8'h54, 8'ha9, 8'haa, 8'h58, 8'he1, 8'hab,
                   8'hac, 8'he2, 8'had, 8'hae, 8'had, 8'haf, 8'hb0, 8'hb1,
                   8'h61, 8'hb2, 8'hb3, 8'hb4, 8'he3, 8'h65, 8'hb6, 8'hb7,
                   8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'h6f, 8'hbe};
        d1_map = '{8'h70, 8'h63, 8'hbf, 8'h79, 8'he4, 8'h78, 8'he5, 8'hc0,
                   8'hc1, 8'he6, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
                   8'h00, 8'hb5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        if (hi == 8'hd0 && lo >= 8'h80 && lo <= 8'hbf)
            m = d0_map[lo - 8'h80];
        else if (hi == 8'hd1 && lo >= 8'h80 && lo <= 8'h9f)
            m = d1_map[lo - 8'h80];
        return (m != 8'h00) ? m : lo;
    endfunction

    function automatic void push_strobe(logic rs, logic [7:0] pins, logic nib,
                                        logic [14:0] wb, logic [10:0] wa);
        t_strobe s;
        s.reg_select     = rs;
        s.read_write     = 1'b0;
        s.data_pins      = pins;
        s.nibble_write   = nib;
        s.wait_before_us = wb;
        s.wait_after_us  = wa;
        s.last           = 1'b0;
        strobe_q.push_back(s);
    endfunction

    function automatic void push_byte(logic rs, logic [7:0] b, logic [10:0] wa);
        if (bus8) begin
            push_strobe(rs, b, 1'b0, 15'd0, wa);
        end else begin
            push_strobe(rs, {b[7:4], 4'h0}, 1'b1, 15'd0, 11'd0);
            push_strobe(rs, {b[3:0], 4'h0}, 1'b1, 15'd0, wa);
        end
    endfunction

    function automatic void predict_strobes(t_cmd c);
        logic [7:0] fset;
        int         n0;
        n0 = strobe_q.size();
        fset = {2'b00, 1'b1, bus8, c.two_line, c.large_font, 2'b00};
        case (t_opcode'(c.opcode))
            OP_CHAR:  push_byte(1'b1, lcd_code(c.char_code), 11'd0);
            OP_CLEAR: push_byte(1'b0, 8'h01, 11'd2000);
            OP_FSET:  push_byte(1'b0, fset, 11'd0);
            OP_ONOFF: push_byte(1'b0, {5'b00001, c.display_on, c.cursor_on,
                                       c.blink_on}, 11'd0);
            OP_ENTRY: push_byte(1'b0, {6'b000001, c.move_forward, c.shift_screen},
                                11'd0);
            OP_POS:   push_byte(1'b0, 8'h80 | ({7'd0, c.row} << 6) + {2'b00, c.column},
                                11'd0);
            OP_INIT: begin
                push_strobe(1'b0, 8'h30, ~bus8, 15'd20000, 11'd0);
                push_strobe(1'b0, 8'h30, ~bus8, 15'd5000, 11'd0);
                push_strobe(1'b0, 8'h30, ~bus8, 15'd1000, 11'd0);
                if (!bus8) begin
                    push_strobe(1'b0, 8'h10, 1'b1, 15'd1000, 11'd0);
                    push_strobe(1'b0, 8'h20, 1'b1, 15'd0, 11'd1000);
                end
                push_byte(1'b0, fset, 11'd0);
                push_byte(1'b0, 8'h08, 11'd0);
                push_byte(1'b0, 8'h01, 11'd2000);
                push_byte(1'b0, 8'h06, 11'd0);
            end
            default: ;
        endcase
        if (strobe_q.size() > n0)
            strobe_q[strobe_q.size() - 1].last = 1'b1;
    endfunction

    function automatic t_cmd rand_cmd(bit any_op);
        t_cmd        c;
        int          k;
        logic [63:0] r;
        r = {$urandom, $urandom};
        c = r[$bits(t_cmd)-1:0];
        k = $urandom_range(0, 99);
        if (any_op)
            c.opcode = (k < 45) ? OP_CHAR : ((k < 50) ? OP_INIT :
                       ((k < 53) ? OP_NONE : 3'($urandom_range(1, 5))));
        if (c.opcode == OP_CHAR && $urandom_range(0, 1))
            c.char_code = {$urandom_range(0, 1) ? CYR_HI_D1 : CYR_HI_D0,
                           8'($urandom_range(8'h70, 8'hc8))};
        return c;
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (cmd_q.size() > 0 && !hold_send) begin
            start <= 1'b1;
            cmd <= cmd_q.pop_front();
            if (gaps_on && $urandom_range(0, 3) == 0)
                gap_left <= $urandom_range(1, 11);
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && start && !busy)
            predict_strobes(cmd);
    end

    // monitor
    always @(posedge clk) begin
        t_strobe e;
        if (rst_n && res_valid) begin
            if (strobe_q.size() == 0) begin
                $error("beat with no expectation: %h", res);
                errors++;
            end else begin
                e = strobe_q.pop_front();
                if (res.reg_select !== e.reg_select) begin
                    $error("reg_select exp %h got %h", e.reg_select, res.reg_select);
                    errors++;
                end
                if (res.read_write !== e.read_write) begin
                    $error("read_write exp %h got %h", e.read_write, res.read_write);
                    errors++;
                end
                if (res.data_pins !== e.data_pins) begin
                    $error("data_pins exp %h got %h", e.data_pins, res.data_pins);
                    errors++;
                end
                if (res.nibble_write !== e.nibble_write) begin
                    $error("nibble_write exp %h got %h", e.nibble_write,
                           res.nibble_write);
                    errors++;
                end
                if (res.wait_before_us !== e.wait_before_us) begin
                    $error("wait_before_us exp %0d got %0d", e.wait_before_us,
                           res.wait_before_us);
                    errors++;
                end
                if (res.wait_after_us !== e.wait_after_us) begin
                    $error("wait_after_us exp %0d got %0d", e.wait_after_us,
                           res.wait_after_us);
                    errors++;
                end
                if (res.last !== e.last) begin
                    $error("last exp %h got %h", e.last, res.last);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        wait (cmd_q.size() == 0);
        @(posedge clk);
        while (start || strobe_q.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_bus(logic v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        bus8 = v;
    endtask

    task automatic load_directed();
        t_cmd c;
        c = '0;
        c.opcode = OP_INIT;
        cmd_q.push_back(c);
        c.opcode = OP_INIT;
        c.two_line = 1'b1;
        c.large_font = 1'b1;
        cmd_q.push_back(c);
        c = '0;
        c.opcode = OP_CHAR;
        cmd_q.push_back(c);
        c.char_code = 16'hffff;
        cmd_q.push_back(c);
        c.char_code = 16'hd090;
        cmd_q.push_back(c);
        c.char_code = 16'hd0bf;
        cmd_q.push_back(c);
        c.char_code = 16'hd081;
        cmd_q.push_back(c);
        c.char_code = 16'hd080;
        cmd_q.push_back(c);
        c.char_code = 16'hd1c0;
        cmd_q.push_back(c);
        c.char_code = 16'hd191;
        cmd_q.push_back(c);
        c.char_code = 16'hd190;
        cmd_q.push_back(c);
        c.char_code = 16'h0041;
        cmd_q.push_back(c);
        c = '0;
        c.opcode = OP_CLEAR;
        cmd_q.push_back(c);
        c.opcode = OP_FSET;
        cmd_q.push_back(c);
        c = '1;
        c.opcode = OP_FSET;
        cmd_q.push_back(c);
        c.opcode = OP_ONOFF;
        cmd_q.push_back(c);
        c.opcode = OP_ENTRY;
        cmd_q.push_back(c);
        c.opcode = OP_POS;
        cmd_q.push_back(c);
        c.opcode = OP_NONE;
        cmd_q.push_back(c);
        c = '0;
        c.opcode = OP_POS;
        cmd_q.push_back(c);
        c.opcode = OP_ONOFF;
        cmd_q.push_back(c);
    endtask

    initial begin
        int n;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        bus8 = 1'b0;
        errors = 0;
        gaps_on = 1'b1;
        hold_send = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        load_directed();
        drain();
        set_bus(1'b1);
        load_directed();
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            set_bus(ph[0]);
            n = (ph == 3) ? 90 : 110;
            if (ph == 3)
                gaps_on = 1'b0;
            for (int i = 0; i < n; i++) begin
                cmd_q.push_back(rand_cmd(1'b1));
                if (ph == 1 && i == 60) begin
                    wait (cmd_q.size() == 0);
                    hold_send = 1'b1;
                    @(posedge clk);
                    while (start || strobe_q.size() > 0)
                        @(posedge clk);
                    hold_send = 1'b0;
                end
            end
            drain();
        end

        if (errors == 0)
            $display("[char_lcd_command_writer] OK");
        else
            $display("[char_lcd_command_writer] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[char_lcd_command_writer] ERROR");
        $finish;
    end

endmodule
